// ----- rtl/lsf_pkg.sv -----
package lsf_pkg;

  localparam int unsigned DIV_STEPS = 31;

  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  typedef enum logic [2:0] {
    OP_N_SXX  = 3'd0,
    OP_SX_SX  = 3'd1,
    OP_N_SXY  = 3'd2,
    OP_SX_SY  = 3'd3,
    OP_SXX_SY = 3'd4,
    OP_SXY_SX = 3'd5
  } op_e;

  typedef struct packed {
    logic take_pair;
    logic mul_load;
    op_e  op;
    logic mul_step;
    logic den_save;
    logic div_load;
    logic div_check;
    logic div_step;
    logic div_store;
    logic sel_offset;
    logic out_load;
  } lsf_cmd_t;

  typedef struct packed {
    logic den_zero;
    logic out_free;
  } lsf_sts_t;

endpackage

// ----- rtl/lsf_datapath.sv -----
module lsf_datapath #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lsf_pkg::lsf_cmd_t cmd_i,
  output lsf_pkg::lsf_sts_t sts_o,
  input  logic [15:0]      x_value_i,
  input  logic [15:0]      y_value_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [31:0]      slope_o,
  output logic [31:0]      offset_o,
  output logic             degenerate_o,
  output logic             overflow_o
);
  import lsf_pkg::*;

  localparam int unsigned LW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned SW = 16 + LW;
  localparam int unsigned PW = 32 + LW;
  localparam int unsigned NW = 2 * LW + 48;
  localparam int unsigned DW = 2 * LW + 31;
  localparam int unsigned RW = NW + 16;

  logic [CW-1:0]        cnt_q;
  logic [SW-1:0]        sx_q, sy_q;
  logic [PW-1:0]        sxx_q, sxy_q;
  logic                 ovf_q;
  logic signed [31:0]   xx, xy;
  logic                 full;

  logic [PW-1:0]        mul_a, a_mag;
  logic [SW-1:0]        mul_b, b_mag;
  logic                 mul_sub;
  logic [NW-1:0]        mcand_q, acc_q, acc_mag;
  logic [SW-1:0]        mplier_q;
  logic                 neg_q;

  logic [DW-1:0]        den_q;
  logic                 degen_q;
  logic [RW-1:0]        rem_q, dsr_q, den_sat;
  logic [DIV_STEPS-1:0] quo_q;
  logic                 num_neg_q, sat_q, round_up;
  logic [31:0]          qr, res, slope_q, offset_q;

  logic                 out_valid_q, out_degen_q, out_ovf_q;
  logic [31:0]          out_slope_q, out_offset_q;

  assign xx   = $signed(x_value_i) * $signed(x_value_i);
  assign xy   = $signed(x_value_i) * $signed(y_value_i);
  assign full = (cnt_q == CW'(MAX_POINTS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sx_q  <= '0;
      sy_q  <= '0;
      sxx_q <= '0;
      sxy_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      cnt_q <= '0;
      sx_q  <= '0;
      sy_q  <= '0;
      sxx_q <= '0;
      sxy_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.take_pair) begin
      if (full) begin
        ovf_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + 1'b1;
        sx_q  <= sx_q + {{(SW-16){x_value_i[15]}}, x_value_i};
        sy_q  <= sy_q + {{(SW-16){y_value_i[15]}}, y_value_i};
        sxx_q <= sxx_q + {{(PW-32){xx[31]}}, xx};
        sxy_q <= sxy_q + {{(PW-32){xy[31]}}, xy};
      end
    end
  end

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_sub = 1'b0;
    case (cmd_i.op)
      OP_N_SXX: begin
        mul_a = sxx_q;
        mul_b = {{(SW-CW){1'b0}}, cnt_q};
      end
      OP_SX_SX: begin
        mul_a   = {{(PW-SW){sx_q[SW-1]}}, sx_q};
        mul_b   = sx_q;
        mul_sub = 1'b1;
      end
      OP_N_SXY: begin
        mul_a = sxy_q;
        mul_b = {{(SW-CW){1'b0}}, cnt_q};
      end
      OP_SX_SY: begin
        mul_a   = {{(PW-SW){sy_q[SW-1]}}, sy_q};
        mul_b   = sx_q;
        mul_sub = 1'b1;
      end
      OP_SXX_SY: begin
        mul_a = sxx_q;
        mul_b = sy_q;
      end
      OP_SXY_SX: begin
        mul_a   = sxy_q;
        mul_b   = sx_q;
        mul_sub = 1'b1;
      end
      default: begin
        mul_a   = '0;
        mul_b   = '0;
        mul_sub = 1'b0;
      end
    endcase
  end

  assign a_mag   = mul_a[PW-1] ? (~mul_a + 1'b1) : mul_a;
  assign b_mag   = mul_b[SW-1] ? (~mul_b + 1'b1) : mul_b;
  assign acc_mag = acc_q[NW-1] ? (~acc_q + 1'b1) : acc_q;
  assign den_sat = {{(RW-DW-31){1'b0}}, den_q, 31'b0};

  assign sts_o.den_zero = acc_q[NW-1] | (acc_q == '0);
  assign sts_o.out_free = !out_valid_q | out_ready_i;

  assign round_up = {rem_q, 1'b0} >= {{(RW+1-DW){1'b0}}, den_q};
  assign qr       = {1'b0, quo_q} + {31'b0, round_up};

  always_comb begin
    if (sat_q) begin
      res = num_neg_q ? SAT_NEG : SAT_POS;
    end else if (num_neg_q) begin
      res = ~qr + 1'b1;
    end else if (qr[31]) begin
      res = SAT_POS;
    end else begin
      res = qr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      mcand_q  <= {{(NW-PW){1'b0}}, a_mag};
      mplier_q <= b_mag;
      neg_q    <= mul_a[PW-1] ^ mul_b[SW-1] ^ mul_sub;
      if (!mul_sub) begin
        acc_q <= '0;
      end
    end
    if (cmd_i.mul_step) begin
      if (mplier_q[0]) begin
        acc_q <= neg_q ? (acc_q - mcand_q) : (acc_q + mcand_q);
      end
      mcand_q  <= {mcand_q[NW-2:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[SW-1:1]};
    end
    if (cmd_i.den_save) begin
      den_q   <= acc_q[DW-1:0];
      degen_q <= sts_o.den_zero;
    end
    if (cmd_i.div_load) begin
      num_neg_q <= acc_q[NW-1];
      rem_q     <= cmd_i.sel_offset ? {8'b0, acc_mag, 8'b0} : {acc_mag, 16'b0};
      dsr_q     <= {{(RW-DW-30){1'b0}}, den_q, 30'b0};
      quo_q     <= '0;
    end
    if (cmd_i.div_check) begin
      sat_q <= rem_q >= den_sat;
    end
    if (cmd_i.div_step) begin
      if (rem_q >= dsr_q) begin
        rem_q <= rem_q - dsr_q;
        quo_q <= {quo_q[DIV_STEPS-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[DIV_STEPS-2:0], 1'b0};
      end
      dsr_q <= {1'b0, dsr_q[RW-1:1]};
    end
    if (cmd_i.div_store) begin
      if (cmd_i.sel_offset) begin
        offset_q <= res;
      end else begin
        slope_q <= res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_slope_q  <= degen_q ? '0 : slope_q;
      out_offset_q <= degen_q ? '0 : offset_q;
      out_degen_q  <= degen_q;
      out_ovf_q    <= ovf_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign slope_o      = out_slope_q;
  assign offset_o     = out_offset_q;
  assign degenerate_o = out_degen_q;
  assign overflow_o   = out_ovf_q;

endmodule

// ----- rtl/lsf_ctrl.sv -----
module lsf_ctrl #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  input  lsf_pkg::lsf_sts_t sts_i,
  output lsf_pkg::lsf_cmd_t cmd_o
);
  import lsf_pkg::*;

  localparam int unsigned SW      = 16 + $clog2(MAX_POINTS);
  localparam int unsigned MAXSTEP = (SW > DIV_STEPS) ? SW : DIV_STEPS;
  localparam int unsigned CNTW    = $clog2(MAXSTEP);

  typedef enum logic [8:0] {
    ST_ACC   = 9'b000000001,
    ST_MLOAD = 9'b000000010,
    ST_MSTEP = 9'b000000100,
    ST_DEN   = 9'b000001000,
    ST_DLOAD = 9'b000010000,
    ST_DCHK  = 9'b000100000,
    ST_DSTEP = 9'b001000000,
    ST_DEND  = 9'b010000000,
    ST_WRITE = 9'b100000000
  } state_e;

  state_e          st_q, st_d;
  op_e             op_q, op_d;
  logic [CNTW-1:0] cnt_q, cnt_d;

  always_comb begin
    st_d           = st_q;
    op_d           = op_q;
    cnt_d          = cnt_q;
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.op       = op_q;
    cmd_o.sel_offset = (op_q == OP_SXY_SX);
    case (st_q)
      ST_ACC: begin
        in_ready_o      = 1'b1;
        cmd_o.take_pair = in_valid_i;
        if (in_valid_i && in_last_i) begin
          op_d = OP_N_SXX;
          st_d = ST_MLOAD;
        end
      end
      ST_MLOAD: begin
        cmd_o.mul_load = 1'b1;
        cnt_d          = '0;
        st_d           = ST_MSTEP;
      end
      ST_MSTEP: begin
        cmd_o.mul_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNTW'(SW - 1)) begin
          case (op_q)
            OP_N_SXX: begin
              op_d = OP_SX_SX;
              st_d = ST_MLOAD;
            end
            OP_SX_SX: st_d = ST_DEN;
            OP_N_SXY: begin
              op_d = OP_SX_SY;
              st_d = ST_MLOAD;
            end
            OP_SX_SY: st_d = ST_DLOAD;
            OP_SXX_SY: begin
              op_d = OP_SXY_SX;
              st_d = ST_MLOAD;
            end
            OP_SXY_SX: st_d = ST_DLOAD;
            default: st_d = ST_ACC;
          endcase
        end
      end
      ST_DEN: begin
        cmd_o.den_save = 1'b1;
        if (sts_i.den_zero) begin
          st_d = ST_WRITE;
        end else begin
          op_d = OP_N_SXY;
          st_d = ST_MLOAD;
        end
      end
      ST_DLOAD: begin
        cmd_o.div_load = 1'b1;
        st_d           = ST_DCHK;
      end
      ST_DCHK: begin
        cmd_o.div_check = 1'b1;
        cnt_d           = '0;
        st_d            = ST_DSTEP;
      end
      ST_DSTEP: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNTW'(DIV_STEPS - 1)) begin
          st_d = ST_DEND;
        end
      end
      ST_DEND: begin
        cmd_o.div_store = 1'b1;
        if (op_q == OP_SXY_SX) begin
          st_d = ST_WRITE;
        end else begin
          op_d = OP_SXX_SY;
          st_d = ST_MLOAD;
        end
      end
      ST_WRITE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          st_d           = ST_ACC;
        end
      end
      default: st_d = ST_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_ACC;
      op_q  <= OP_N_SXX;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      op_q  <= op_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- rtl/least_squares_line_fit_unit.sv -----
// Channel  Dir  Transfer                 Contents
// s_axis   in   tvalid & tready          tdata {y_value, x_value}, tlast = last_pair
// m_axis   out  tvalid & tready          tdata {offset, slope}, tuser {overflow, degenerate}
//
// Pairs are taken one per cycle while accumulating; after the last pair the fit runs on
// one shift-add multiplier (multiplier operand SW = 16 + clog2(MAX_POINTS) bits) and one
// restoring divider; a zero denominator ends it early. s_axis_tready is low during the fit;
// the result register holds one transaction, and the next set accumulates while it waits
// on m_axis_tready. Reset clears the sums, the pair count and the output valid flag.
module least_squares_line_fit_unit #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] x_value, [31:16] y_value
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] slope, [63:32] offset
  output logic [1:0]  m_axis_tuser    // [0] degenerate, [1] overflow
);
  import lsf_pkg::*;

  lsf_cmd_t    cmd;
  lsf_sts_t    sts;
  logic [31:0] slope, offset;
  logic        degenerate, overflow;

  lsf_ctrl #(
    .MAX_POINTS(MAX_POINTS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lsf_datapath #(
    .MAX_POINTS(MAX_POINTS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .x_value_i    (s_axis_tdata[15:0]),
    .y_value_i    (s_axis_tdata[31:16]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .slope_o      (slope),
    .offset_o     (offset),
    .degenerate_o (degenerate),
    .overflow_o   (overflow)
  );

  assign m_axis_tdata = {offset, slope};
  assign m_axis_tuser = {overflow, degenerate};

`ifndef ASSERT_OFF
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over a pending transaction");

  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("pair accepted during fit");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("degenerate result with nonzero fit");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.take_pair, cmd.mul_load, cmd.mul_step, cmd.den_save, cmd.div_load,
              cmd.div_check, cmd.div_step, cmd.div_store, cmd.out_load}))
    else $error("overlapping datapath commands");
`endif

endmodule
